>>> hw/rtl/vdk4_pkg.sv
// ----------------------------------------------------------------------------
// vdk4_pkg
// Shared constants, types and helpers for the K=4 rate 1/2 Viterbi decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vdk4_pkg;

    localparam int SURVIVOR_BITS_DEF = 32;
    localparam int TABLE_WIDTH_DEF   = 16;
    localparam int METRIC_WIDTH_DEF  = 48;
    localparam int NUM_STATES        = 8;
    localparam int TABLE_COLS        = 256;
    localparam int FINAL_W           = 48;
    localparam int START_METRIC      = -999999;

    localparam logic OP_DECODE      = 1'b0;
    localparam logic OP_TABLE_WRITE = 1'b1;

    // expected symbol pair index for the upper branch of each butterfly
    localparam logic [1:0] BFLY_SYM [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

    typedef struct packed {
        logic       en;
        logic       row;
        logic [7:0] col;
    } tbl_wr_t;

    typedef struct packed {
        logic       reg_emit;
        logic       last;
        logic [2:0] rem;
    } emit_flags_t;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[7 - k] = b[k];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/vdk4_pair_if.sv
// ----------------------------------------------------------------------------
// vdk4_pair_if
// Input channel: symbol pairs and metric table writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface vdk4_pair_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [7:0]         sym_first;
    logic [7:0]         sym_second;
    logic               last_pair;
    logic               table_row;
    logic [7:0]         table_col;
    logic signed [15:0] table_value;

    modport source (
        output valid, op, sym_first, sym_second, last_pair, table_row, table_col,
               table_value,
        input  ready
    );

    modport sink (
        input  valid, op, sym_first, sym_second, last_pair, table_row, table_col,
               table_value,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/vdk4_byte_if.sv
// ----------------------------------------------------------------------------
// vdk4_byte_if
// Output channel: decoded bytes with end-of-frame mark and final metric.
// ----------------------------------------------------------------------------
`default_nettype none

interface vdk4_byte_if;
    logic                                valid;
    logic                                ready;
    logic [7:0]                          data_byte;
    logic                                last_byte;
    logic signed [vdk4_pkg::FINAL_W-1:0] final_metric;

    modport source (
        output valid, data_byte, last_byte, final_metric,
        input  ready
    );

    modport sink (
        input  valid, data_byte, last_byte, final_metric,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/vdk4_bm_table.sv
// ----------------------------------------------------------------------------
// vdk4_bm_table
// Branch metric table, two rows of 256 entries, one write and two reads per row.
// ----------------------------------------------------------------------------
`default_nettype none

module vdk4_bm_table #(
    parameter int TABLE_WIDTH = vdk4_pkg::TABLE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire vdk4_pkg::tbl_wr_t             wr,
    input  wire logic signed [TABLE_WIDTH-1:0] wr_data,
    input  wire logic                          rd_en,
    input  wire logic [7:0]                    addr_a,
    input  wire logic [7:0]                    addr_b,
    output logic signed [TABLE_WIDTH-1:0]      rd_a0,
    output logic signed [TABLE_WIDTH-1:0]      rd_b0,
    output logic signed [TABLE_WIDTH-1:0]      rd_a1,
    output logic signed [TABLE_WIDTH-1:0]      rd_b1
);
    import vdk4_pkg::*;

    logic signed [TABLE_WIDTH-1:0] row0_mem [TABLE_COLS];
    logic signed [TABLE_WIDTH-1:0] row1_mem [TABLE_COLS];

    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.row)
        begin
            row0_mem[wr.col] <= wr_data;
        end
        if (wr.en && wr.row)
        begin
            row1_mem[wr.col] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a0 <= row0_mem[addr_a];
            rd_b0 <= row0_mem[addr_b];
            rd_a1 <= row1_mem[addr_a];
            rd_b1 <= row1_mem[addr_b];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/vdk4_acs.sv
// ----------------------------------------------------------------------------
// vdk4_acs
// One trellis step: four butterflies of saturating add-compare-select with
// register-exchange survivor update.
// ----------------------------------------------------------------------------
`default_nettype none

module vdk4_acs #(
    parameter int SURVIVOR_BITS = vdk4_pkg::SURVIVOR_BITS_DEF,
    parameter int TABLE_WIDTH   = vdk4_pkg::TABLE_WIDTH_DEF,
    parameter int METRIC_WIDTH  = vdk4_pkg::METRIC_WIDTH_DEF
) (
    input  wire logic signed [METRIC_WIDTH-1:0] pm_in  [vdk4_pkg::NUM_STATES],
    input  wire logic [SURVIVOR_BITS-1:0]       sv_in  [vdk4_pkg::NUM_STATES],
    input  wire logic signed [TABLE_WIDTH:0]    mets   [4],
    output logic signed [METRIC_WIDTH-1:0]      pm_out [vdk4_pkg::NUM_STATES],
    output logic [SURVIVOR_BITS-1:0]            sv_out [vdk4_pkg::NUM_STATES]
);
    import vdk4_pkg::*;

    localparam int MW  = METRIC_WIDTH;
    localparam int SB  = SURVIVOR_BITS;
    localparam int MTW = TABLE_WIDTH + 1;
    localparam int SW  = ((MW > MTW) ? MW : MTW) + 1;

    localparam logic signed [MW-1:0] PM_MAX = {1'b0, {(MW - 1){1'b1}}};
    localparam logic signed [MW-1:0] PM_MIN = {1'b1, {(MW - 1){1'b0}}};

    function automatic logic signed [MW-1:0] sat_add(
        input logic signed [MW-1:0]  a,
        input logic signed [MTW-1:0] b
    );
        logic signed [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (!s[SW-1] && (|s[SW-2:MW-1]))
        begin
            return PM_MAX;
        end
        else if (s[SW-1] && !(&s[SW-2:MW-1]))
        begin
            return PM_MIN;
        end
        return s[MW-1:0];
    endfunction

    for (genvar g = 0; g < 4; g++)
    begin : g_bfly
        localparam logic [1:0] SY  = BFLY_SYM[g];
        localparam logic [1:0] SYC = ~SY;

        logic signed [MW-1:0] a0, b0, a1, b1;
        logic                 up0, up1;
        logic [SB-1:0]        sel0, sel1;

        always_comb
        begin
            a0   = sat_add(pm_in[g],     mets[SY]);
            b0   = sat_add(pm_in[g + 4], mets[SYC]);
            a1   = sat_add(pm_in[g],     mets[SYC]);
            b1   = sat_add(pm_in[g + 4], mets[SY]);
            up0  = a0 > b0;
            up1  = a1 > b1;
            sel0 = up0 ? sv_in[g] : sv_in[g + 4];
            sel1 = up1 ? sv_in[g] : sv_in[g + 4];
            pm_out[2 * g]     = up0 ? a0 : b0;
            pm_out[2 * g + 1] = up1 ? a1 : b1;
            sv_out[2 * g]     = {sel0[SB-2:0], 1'b0};
            sv_out[2 * g + 1] = {sel1[SB-2:0], 1'b1};
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/viterbi_decoder_k4_rate_half.sv
// ----------------------------------------------------------------------------
// viterbi_decoder_k4_rate_half
// Soft-decision register-exchange Viterbi decoder, K=4, rate 1/2 (0xf, 0xd).
// ----------------------------------------------------------------------------
//  channel   | dir | transaction
//  pair_in   | in  | symbol pair to decode, or one metric table write
//  byte_out  | out | decoded byte, end-of-frame mark, final path metric
//
//  One pair or table write is taken per cycle; a trellis step is done by the
//  ACS unit in the cycle after the table read. Bytes pass from the state
//  registers through a best-state compare tree of three stages to the output.
//  A flush gives up to four bytes, one per cycle while byte_out is ready;
//  pair_in stalls only while a further byte group sits at the tree output
//  behind bytes not yet taken. Reset is asynchronous; the metric table is not
//  cleared and holds its contents across frames.
// ----------------------------------------------------------------------------
`default_nettype none

module viterbi_decoder_k4_rate_half #(
    parameter int SURVIVOR_BITS = vdk4_pkg::SURVIVOR_BITS_DEF,
    parameter int TABLE_WIDTH   = vdk4_pkg::TABLE_WIDTH_DEF,
    parameter int METRIC_WIDTH  = vdk4_pkg::METRIC_WIDTH_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    vdk4_pair_if.sink    pair_in,
    vdk4_byte_if.source  byte_out
);
    import vdk4_pkg::*;

    localparam int SB  = SURVIVOR_BITS;
    localparam int TW  = TABLE_WIDTH;
    localparam int MW  = METRIC_WIDTH;
    localparam int MTW = TW + 1;
    localparam int PW  = (SB > 24) ? SB : 24;

    logic                 adv, accept, dec_accept;
    tbl_wr_t              tbl_wr;
    logic signed [TW-1:0] tbl_data;
    logic signed [TW-1:0] r0a, r0b, r1a, r1b;
    logic signed [MTW-1:0] mets [4];

    logic s1_valid_reg, s1_last_reg;

    logic signed [MW-1:0] pm_reg [NUM_STATES];
    logic signed [MW-1:0] pm_eff [NUM_STATES];
    logic signed [MW-1:0] pm_acs [NUM_STATES];
    logic signed [MW-1:0] pm_next [NUM_STATES];
    logic [SB-1:0]        sv_reg [NUM_STATES];
    logic [SB-1:0]        sv_eff [NUM_STATES];
    logic [SB-1:0]        sv_acs [NUM_STATES];
    logic [SB-1:0]        sv_next [NUM_STATES];
    logic [15:0]          bc_reg, bc_eff, bc_next;
    logic                 wf_reg, wf_eff, wf_next;
    logic                 s2_end;

    emit_flags_t s2_flags_reg, s2_flags_next, s3_flags_reg, s4_flags_reg, s5_flags_reg;
    logic        s2_valid_reg, s2_valid_next, s3_valid_reg, s4_valid_reg, s5_valid_reg;

    logic signed [MW-1:0] s3_pm_reg [4];
    logic [SB-1:0]        s3_sv_reg [4];
    logic signed [MW-1:0] s4_pm_reg [2];
    logic [SB-1:0]        s4_sv_reg [2];
    logic signed [MW-1:0] s5_pm_reg;
    logic [SB-1:0]        s5_sv_reg;

    logic [7:0]              q_reg [4];
    logic [2:0]              cnt_reg;
    logic                    seq_last_reg;
    logic signed [FINAL_W-1:0] seq_metric_reg;
    logic                    load, out_fire;

    logic [7:0]    top_byte, first_byte, b_hi, b_mid, b_lo;
    logic [3:0]    sh_amt;
    logic [SB-1:0] shifted, p_sel;
    logic [PW-1:0] p_ext;
    logic          first_present;

    // ---------------------------------------------------------------- input
    assign adv           = !(s5_valid_reg && cnt_reg != 3'd0);
    assign pair_in.ready = adv;
    assign accept        = pair_in.valid && adv;
    assign dec_accept    = accept && (pair_in.op == OP_DECODE);

    assign tbl_wr.en  = accept && (pair_in.op == OP_TABLE_WRITE);
    assign tbl_wr.row = pair_in.table_row;
    assign tbl_wr.col = pair_in.table_col;
    assign tbl_data   = TW'(pair_in.table_value);

    vdk4_bm_table #(
        .TABLE_WIDTH(TW)
    ) u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .wr_data (tbl_data),
        .rd_en   (dec_accept),
        .addr_a  (pair_in.sym_first),
        .addr_b  (pair_in.sym_second),
        .rd_a0   (r0a),
        .rd_b0   (r0b),
        .rd_a1   (r1a),
        .rd_b1   (r1b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= dec_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_last_reg <= pair_in.last_pair;
        end
    end

    // ---------------------------------------------------------------- ACS
    always_comb
    begin
        mets[0] = MTW'(r0a) + MTW'(r0b);
        mets[1] = MTW'(r0a) + MTW'(r1b);
        mets[2] = MTW'(r1a) + MTW'(r0b);
        mets[3] = MTW'(r1a) + MTW'(r1b);
    end

    // a frame ending in stage 2 hands the reset state to the next step
    always_comb
    begin
        s2_end = s2_valid_reg && s2_flags_reg.last;
        for (int i = 0; i < NUM_STATES; i++)
        begin
            if (s2_end)
            begin
                pm_eff[i] = (i == 0) ? '0 : MW'(START_METRIC);
                sv_eff[i] = '0;
            end
            else
            begin
                pm_eff[i] = pm_reg[i];
                sv_eff[i] = sv_reg[i];
            end
        end
        bc_eff = s2_end ? 16'd0 : bc_reg;
        wf_eff = s2_end ? 1'b0 : wf_reg;
    end

    vdk4_acs #(
        .SURVIVOR_BITS(SB),
        .TABLE_WIDTH  (TW),
        .METRIC_WIDTH (MW)
    ) u_acs (
        .pm_in  (pm_eff),
        .sv_in  (sv_eff),
        .mets   (mets),
        .pm_out (pm_acs),
        .sv_out (sv_acs)
    );

    always_comb
    begin
        for (int i = 0; i < NUM_STATES; i++)
        begin
            pm_next[i] = s1_valid_reg ? pm_acs[i] : pm_eff[i];
            sv_next[i] = s1_valid_reg ? sv_acs[i] : sv_eff[i];
        end
        bc_next = s1_valid_reg ? bc_eff + 16'd1 : bc_eff;
        wf_next = s1_valid_reg ? (wf_eff || (bc_next >= 16'(SB))) : wf_eff;

        s2_flags_next.reg_emit = wf_next && (bc_next[2:0] == 3'd0);
        s2_flags_next.last     = s1_last_reg;
        s2_flags_next.rem      = bc_next[2:0];
        s2_valid_next          = s1_valid_reg &&
                                 (s2_flags_next.reg_emit || s2_flags_next.last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STATES; i++)
            begin
                pm_reg[i] <= (i == 0) ? '0 : MW'(START_METRIC);
                sv_reg[i] <= '0;
            end
            bc_reg       <= 16'd0;
            wf_reg       <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s2_flags_reg <= '0;
        end
        else if (adv)
        begin
            pm_reg       <= pm_next;
            sv_reg       <= sv_next;
            bc_reg       <= bc_next;
            wf_reg       <= wf_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s2_flags_reg <= s2_flags_next;
        end
    end

    // ---------------------------------------------------------------- best state
    // strict compare keeps the lower state index on a tie
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (pm_reg[2 * j + 1] > pm_reg[2 * j])
                begin
                    s3_pm_reg[j] <= pm_reg[2 * j + 1];
                    s3_sv_reg[j] <= sv_reg[2 * j + 1];
                end
                else
                begin
                    s3_pm_reg[j] <= pm_reg[2 * j];
                    s3_sv_reg[j] <= sv_reg[2 * j];
                end
            end
            for (int j = 0; j < 2; j++)
            begin
                if (s3_pm_reg[2 * j + 1] > s3_pm_reg[2 * j])
                begin
                    s4_pm_reg[j] <= s3_pm_reg[2 * j + 1];
                    s4_sv_reg[j] <= s3_sv_reg[2 * j + 1];
                end
                else
                begin
                    s4_pm_reg[j] <= s3_pm_reg[2 * j];
                    s4_sv_reg[j] <= s3_sv_reg[2 * j];
                end
            end
            if (s4_pm_reg[1] > s4_pm_reg[0])
            begin
                s5_pm_reg <= s4_pm_reg[1];
                s5_sv_reg <= s4_sv_reg[1];
            end
            else
            begin
                s5_pm_reg <= s4_pm_reg[0];
                s5_sv_reg <= s4_sv_reg[0];
            end
            s3_flags_reg <= s2_flags_reg;
            s4_flags_reg <= s3_flags_reg;
            s5_flags_reg <= s4_flags_reg;
        end
    end

    // ---------------------------------------------------------------- bytes
    always_comb
    begin
        top_byte      = rev8(s5_sv_reg[SB-1 -: 8]);
        sh_amt        = 4'd8 - {1'b0, s5_flags_reg.rem};
        shifted       = s5_sv_reg << sh_amt;
        p_sel         = (s5_flags_reg.rem != 3'd0) ? shifted : s5_sv_reg;
        p_ext         = PW'(p_sel);
        b_hi          = rev8(p_ext[23:16]);
        b_mid         = rev8(p_ext[15:8]);
        b_lo          = rev8(p_ext[7:0]);
        first_byte    = s5_flags_reg.reg_emit ? top_byte : rev8(shifted[SB-1 -: 8]);
        first_present = s5_flags_reg.reg_emit ||
                        (s5_flags_reg.last && s5_flags_reg.rem != 3'd0);
    end

    assign load     = adv && s5_valid_reg;
    assign out_fire = byte_out.valid && byte_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else if (load)
        begin
            cnt_reg <= 3'({2'b00, first_present}) + (s5_flags_reg.last ? 3'd3 : 3'd0);
        end
        else if (out_fire)
        begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (first_present)
            begin
                q_reg[0] <= first_byte;
                q_reg[1] <= b_hi;
                q_reg[2] <= b_mid;
                q_reg[3] <= b_lo;
            end
            else
            begin
                q_reg[0] <= b_hi;
                q_reg[1] <= b_mid;
                q_reg[2] <= b_lo;
                q_reg[3] <= b_lo;
            end
            seq_last_reg   <= s5_flags_reg.last;
            seq_metric_reg <= FINAL_W'(s5_pm_reg);
        end
        else if (out_fire)
        begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
            q_reg[2] <= q_reg[3];
        end
    end

    assign byte_out.valid        = cnt_reg != 3'd0;
    assign byte_out.data_byte    = q_reg[0];
    assign byte_out.last_byte    = seq_last_reg && (cnt_reg == 3'd1);
    assign byte_out.final_metric = byte_out.last_byte ? seq_metric_reg : '0;

endmodule

`default_nettype wire
